@@ rtl/core/idf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idf_pkg: shared types and constants of the direct-form-I IIR filter
// Field widths, command and register codes, and the command/status bundles
// that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package idf_pkg;

  // Field widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int TAPS_W    = 6;
  localparam int IDX_W     = 5;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 1;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FF_TAPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FB_TAPS = 1'd1;

  // Configuration reset values
  localparam logic [TAPS_W-1:0] FF_TAPS_RST = 6'd1;
  localparam logic [TAPS_W-1:0] FB_TAPS_RST = 6'd0;

  // Saturation limits of an output sample
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Sequencer to datapath commands
  typedef struct packed {
    logic load;      // capture the accepted item
    logic push_in;   // shift the sample into the input history, clear sum
    logic ff_rd;     // issue one feed-forward tap
    logic fb_start;  // rewind the tap counter for the feedback walk
    logic fb_rd;     // issue one feedback tap
    logic round;     // round, saturate and push the newest output
    logic wr_ff;     // write one feed-forward coefficient
    logic wr_fb;     // write one feedback coefficient
    logic clear;     // clear both histories
  } idf_cmd_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic ff_end;    // all feed-forward taps issued
    logic fb_end;    // all feedback taps issued
    logic busy;      // multiply-accumulate pipeline not empty
  } idf_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/idf_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idf_dp: filter datapath
// History rings, coefficient stores, tap counter and the shared
// multiply-accumulate pipeline (read, multiply, accumulate), plus rounding.
// ----------------------------------------------------------------------------
module idf_dp import idf_pkg::*; #(
  parameter int MAX_FF_TAPS = 32,
  parameter int MAX_FB_TAPS = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  idf_cmd_t                    ctl,
  output idf_stat_t                   sts,
  input  wire        [TAPS_W-1:0]     ff_taps,
  input  wire        [TAPS_W-1:0]     fb_taps,
  input  wire        [IDX_W-1:0]      tap_index,
  input  wire signed [COEF_W-1:0]     coef_value,
  input  wire signed [SAMPLE_W-1:0]   sample_in,
  output logic signed [SAMPLE_W-1:0]  last_out,
  output logic                        res_ovf
);

  localparam int FF_AW  = (MAX_FF_TAPS > 1) ? $clog2(MAX_FF_TAPS) : 1;
  localparam int FB_AW  = (MAX_FB_TAPS > 1) ? $clog2(MAX_FB_TAPS) : 1;
  localparam int MAXT   = (MAX_FF_TAPS > MAX_FB_TAPS) ? MAX_FF_TAPS : MAX_FB_TAPS;
  localparam int CNT_W  = $clog2(MAXT + 1);
  localparam int FC_W   = $clog2(MAX_FF_TAPS + 1);
  localparam int BC_W   = $clog2(MAX_FB_TAPS + 1);
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_FF_TAPS + MAX_FB_TAPS) + 1;
  localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC - 1);

  // Captured item fields
  logic        [IDX_W-1:0]    idx_l;
  logic signed [COEF_W-1:0]   cval_l;
  logic signed [SAMPLE_W-1:0] smp_l;

  // History rings: pointer at newest entry, fill count of live entries
  logic signed [SAMPLE_W-1:0] in_mem  [MAX_FF_TAPS];
  logic signed [SAMPLE_W-1:0] out_mem [MAX_FB_TAPS];
  logic [FF_AW-1:0] in_ptr, in_ptr_next, in_raddr;
  logic [FB_AW-1:0] out_ptr, out_ptr_next, out_raddr;
  logic [FC_W-1:0]  in_count;
  logic [BC_W-1:0]  out_count;

  // Coefficient stores with per-entry valid bits
  logic signed [COEF_W-1:0] ff_cmem [MAX_FF_TAPS];
  logic signed [COEF_W-1:0] fb_cmem [MAX_FB_TAPS];
  logic [MAX_FF_TAPS-1:0]   ff_cv;
  logic [MAX_FB_TAPS-1:0]   fb_cv;
  logic ff_wr_ok, fb_wr_ok;

  // Tap walk
  logic [CNT_W-1:0] cnt, nf, nb;
  logic [FF_AW-1:0] ff_caddr;
  logic [FB_AW-1:0] fb_caddr;

  // Pipeline
  logic                       s1_v, s1_fb, s1_ok;
  logic signed [SAMPLE_W-1:0] ih_q, oh_q;
  logic signed [COEF_W-1:0]   ffc_q, fbc_q;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [COEF_W-1:0]   op_b;
  logic                       s2_v, s2_neg;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  // Rounding
  logic signed [ACC_W-1:0]    rsum, yfull;
  logic [ACC_W-SAMPLE_W:0]    yhi;
  logic                       yfits;
  logic signed [SAMPLE_W-1:0] ysat;

  // Clamp tap counts to the store depths
  assign nf = (32'(ff_taps) > MAX_FF_TAPS) ? CNT_W'(MAX_FF_TAPS) : CNT_W'(ff_taps);
  assign nb = (32'(fb_taps) > MAX_FB_TAPS) ? CNT_W'(MAX_FB_TAPS) : CNT_W'(fb_taps);

  assign ff_caddr = FF_AW'(cnt);
  assign fb_caddr = FB_AW'(cnt);

  assign in_ptr_next  = (in_ptr == FF_AW'(MAX_FF_TAPS - 1)) ? '0 : in_ptr + FF_AW'(1);
  assign out_ptr_next = (out_ptr == FB_AW'(MAX_FB_TAPS - 1)) ? '0 : out_ptr + FB_AW'(1);

  assign ff_wr_ok = 32'(idx_l) < MAX_FF_TAPS;
  assign fb_wr_ok = 32'(idx_l) < MAX_FB_TAPS;

  assign sts.ff_end = cnt >= nf;
  assign sts.fb_end = cnt >= nb;
  assign sts.busy   = s1_v | s2_v;

  // Capture item fields
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx_l  <= tap_index;
      cval_l <= coef_value;
      smp_l  <= sample_in;
    end
  end

  // Input history memory
  always_ff @(posedge clk) begin
    if (ctl.push_in) begin
      in_mem[in_ptr_next] <= smp_l;
    end
    if (ctl.ff_rd) begin
      ih_q <= in_mem[in_raddr];
    end
  end

  // Output history memory
  always_ff @(posedge clk) begin
    if (ctl.round) begin
      out_mem[out_ptr_next] <= ysat;
    end
    if (ctl.fb_rd) begin
      oh_q <= out_mem[out_raddr];
    end
  end

  // Feed-forward coefficient memory
  always_ff @(posedge clk) begin
    if (ctl.wr_ff && ff_wr_ok) begin
      ff_cmem[FF_AW'(idx_l)] <= cval_l;
    end
    if (ctl.ff_rd) begin
      ffc_q <= ff_cmem[ff_caddr];
    end
  end

  // Feedback coefficient memory
  always_ff @(posedge clk) begin
    if (ctl.wr_fb && fb_wr_ok) begin
      fb_cmem[FB_AW'(idx_l)] <= cval_l;
    end
    if (ctl.fb_rd) begin
      fbc_q <= fb_cmem[fb_caddr];
    end
  end

  // Ring pointers, fill counts, valid bits and tap counter
  always_ff @(posedge clk) begin
    if (rst) begin
      in_ptr    <= '0;
      out_ptr   <= '0;
      in_raddr  <= '0;
      out_raddr <= '0;
      in_count  <= '0;
      out_count <= '0;
      ff_cv     <= '0;
      fb_cv     <= '0;
      cnt       <= '0;
    end else begin
      if (ctl.push_in) begin
        in_ptr   <= in_ptr_next;
        in_raddr <= in_ptr_next;
        cnt      <= '0;
        if (32'(in_count) < MAX_FF_TAPS) begin
          in_count <= in_count + FC_W'(1);
        end
      end
      if (ctl.ff_rd) begin
        in_raddr <= (in_raddr == '0) ? FF_AW'(MAX_FF_TAPS - 1) : in_raddr - FF_AW'(1);
        cnt      <= cnt + CNT_W'(1);
      end
      if (ctl.fb_start) begin
        out_raddr <= out_ptr;
        cnt       <= '0;
      end
      if (ctl.fb_rd) begin
        out_raddr <= (out_raddr == '0) ? FB_AW'(MAX_FB_TAPS - 1) : out_raddr - FB_AW'(1);
        cnt       <= cnt + CNT_W'(1);
      end
      if (ctl.round) begin
        out_ptr <= out_ptr_next;
        if (32'(out_count) < MAX_FB_TAPS) begin
          out_count <= out_count + BC_W'(1);
        end
      end
      if (ctl.clear) begin
        in_count  <= '0;
        out_count <= '0;
      end
      if (ctl.wr_ff && ff_wr_ok) begin
        ff_cv[FF_AW'(idx_l)] <= 1'b1;
      end
      if (ctl.wr_fb && fb_wr_ok) begin
        fb_cv[FB_AW'(idx_l)] <= 1'b1;
      end
    end
  end

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= ctl.ff_rd | ctl.fb_rd;
      s2_v <= s1_v;
    end
  end

  // Read stage side info: tap live only if history entry and coefficient exist
  always_ff @(posedge clk) begin
    if (ctl.ff_rd) begin
      s1_fb <= 1'b0;
      s1_ok <= (32'(cnt) < 32'(in_count)) && ff_cv[ff_caddr];
    end else if (ctl.fb_rd) begin
      s1_fb <= 1'b1;
      s1_ok <= (32'(cnt) < 32'(out_count)) && fb_cv[fb_caddr];
    end
  end

  // Multiply stage
  assign op_a = s1_fb ? oh_q : ih_q;
  assign op_b = s1_fb ? fbc_q : ffc_q;

  always_ff @(posedge clk) begin
    if (s1_v) begin
      if (s1_ok) begin
        prod <= op_a * op_b;
      end else begin
        prod <= '0;
      end
      s2_neg <= s1_fb;
    end
  end

  // Accumulate stage: add feed-forward, subtract feedback products
  always_ff @(posedge clk) begin
    if (ctl.push_in) begin
      acc <= '0;
    end else if (s2_v) begin
      acc <= s2_neg ? acc - ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // Round half up, drop fraction, saturate
  assign rsum  = acc + signed'(RND);
  assign yfull = rsum >>> COEF_FRAC;
  assign yhi   = yfull[ACC_W-1:SAMPLE_W-1];
  assign yfits = (&yhi) | ~(|yhi);
  assign ysat  = yfits ? yfull[SAMPLE_W-1:0] :
                 (yhi[ACC_W-SAMPLE_W] ? signed'(SAMPLE_MIN) : signed'(SAMPLE_MAX));

  // Newest output and overflow flag of the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_out <= '0;
      res_ovf  <= 1'b0;
    end else begin
      if (ctl.round) begin
        last_out <= ysat;
        res_ovf  <= ~yfits;
      end
      if (ctl.wr_ff || ctl.wr_fb) begin
        res_ovf <= 1'b0;
      end
      if (ctl.clear) begin
        last_out <= '0;
        res_ovf  <= 1'b0;
      end
    end
  end

  // Checks
  a_round_drained: assert property (@(posedge clk) disable iff (rst)
    ctl.round |-> !s1_v && !s2_v)
    else $error("round issued with products still in flight");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> in_count == '0 && out_count == '0 && last_out == '0)
    else $error("clear left history state behind");

  a_ff_in_range: assert property (@(posedge clk) disable iff (rst)
    ctl.ff_rd |-> cnt < nf)
    else $error("feed-forward tap issued past tap count");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (rst)
    res_ovf |-> (last_out == signed'(SAMPLE_MAX) || last_out == signed'(SAMPLE_MIN)))
    else $error("overflow flagged on an unsaturated output");

endmodule
`default_nettype wire

@@ rtl/core/idf_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// idf_ctrl: filter sequencer
// Accepts one item at a time and steps the datapath through the input push, the
// feed-forward/feedback tap walks, drain, rounding (or a write or clear), delivery.
// ----------------------------------------------------------------------------
module idf_ctrl import idf_pkg::*; (
  input  wire               clk,
  input  wire               rst,
  input  wire               req_valid,
  output logic              req_stall,
  input  wire  [CMD_W-1:0]  cmd,
  output idf_cmd_t          ctl,
  input  idf_stat_t         sts,
  input  wire               rsp_free,
  output logic              deliver
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PUSH  = 3'd1;
  localparam logic [2:0] ST_FFW   = 3'd2;
  localparam logic [2:0] ST_FBW   = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_EXEC  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]       state, state_next;
  logic [CMD_W-1:0] op;
  logic             accept;

  assign req_stall = state != ST_IDLE;
  assign accept    = req_valid && !req_stall;

  // Hold the command of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one item
  always_comb begin
    state_next = state;
    ctl        = '0;
    deliver    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.load   = 1'b1;
          state_next = (cmd == CMD_SAMPLE) ? ST_PUSH : ST_EXEC;
        end
      end
      ST_PUSH: begin
        ctl.push_in = 1'b1;
        state_next  = ST_FFW;
      end
      ST_FFW: begin
        if (sts.ff_end) begin
          ctl.fb_start = 1'b1;
          state_next   = ST_FBW;
        end else begin
          ctl.ff_rd = 1'b1;
        end
      end
      ST_FBW: begin
        if (sts.fb_end) begin
          state_next = ST_DRAIN;
        end else begin
          ctl.fb_rd = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round  = 1'b1;
        state_next = ST_DONE;
      end
      ST_EXEC: begin
        case (op)
          CMD_WR_FF: ctl.wr_ff = 1'b1;
          CMD_WR_FB: ctl.wr_fb = 1'b1;
          CMD_CLEAR: ctl.clear = 1'b1;
          default:   ;
        endcase
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_free) begin
          deliver    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Checks
  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && rsp_free) |=> state == ST_IDLE)
    else $error("result delivered but sequencer did not return to idle");

  a_one_walk: assert property (@(posedge clk) disable iff (rst)
    !(ctl.ff_rd && ctl.fb_rd))
    else $error("both tap walks issued at once");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_PUSH || state == ST_EXEC))
    else $error("accepted item did not start");

endmodule
`default_nettype wire

@@ rtl/core/iir_direct_form_filter_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iir_direct_form_filter_top: direct-form-I IIR filter
// A sample walks nf feed-forward and then nb feedback taps, where nf and nb are the
// taps in use, one tap per cycle through the shared multiply-accumulate; then the
// pipeline drains, the sum is rounded and the result goes to the result register.
// A new item is accepted only once the previous one has been delivered.
// Reset clears histories, coefficients and the result; ff_taps = 1, fb_taps = 0.
// ----------------------------------------------------------------------------
module iir_direct_form_filter_top import idf_pkg::*; #(
  parameter int MAX_FF_TAPS = 32,
  parameter int MAX_FB_TAPS = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  // item channel
  input  wire                         req_valid,
  output logic                        req_stall,
  input  wire        [CMD_W-1:0]      cmd,
  input  wire        [IDX_W-1:0]      tap_index,
  input  wire signed [COEF_W-1:0]     coef_value,
  input  wire signed [SAMPLE_W-1:0]   sample_in,
  // result channel
  output logic                        rsp_valid,
  input  wire                         rsp_stall,
  output logic signed [SAMPLE_W-1:0]  sample_out,
  output logic                        overflow,
  // configuration write channel
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire        [CFG_IDX_W-1:0]  cfg_index,
  input  wire        [TAPS_W-1:0]     cfg_data
);

  logic [TAPS_W-1:0]          ff_taps, fb_taps;
  idf_cmd_t                   ctl;
  idf_stat_t                  sts;
  logic                       rsp_free, deliver;
  logic signed [SAMPLE_W-1:0] last_out;
  logic                       res_ovf;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ff_taps <= FF_TAPS_RST;
      fb_taps <= FB_TAPS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FF_TAPS: ff_taps <= cfg_data;
        REG_FB_TAPS: fb_taps <= cfg_data;
        default:     ;
      endcase
    end
  end

  idf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .ctl       (ctl),
    .sts       (sts),
    .rsp_free  (rsp_free),
    .deliver   (deliver)
  );

  idf_dp #(
    .MAX_FF_TAPS (MAX_FF_TAPS),
    .MAX_FB_TAPS (MAX_FB_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .ff_taps    (ff_taps),
    .fb_taps    (fb_taps),
    .tap_index  (tap_index),
    .coef_value (coef_value),
    .sample_in  (sample_in),
    .last_out   (last_out),
    .res_ovf    (res_ovf)
  );

  // Result register: load on delivery, drop once taken
  assign rsp_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (deliver) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      sample_out <= last_out;
      overflow   <= res_ovf;
    end
  end

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench of the direct-form-I IIR filter
// Sends directed and random command items under varied tap settings and
// idling, predicts every result with a bit-accurate filter model kept in a
// scoreboard, and checks each output item in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import idf_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int NUM_TAPS       = 32;
  localparam int PHASE_ITEMS    = 200;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // One filter output item
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ovf;
  } filt_out_t;

  // Filter predictor and queue of expected output items
  class filter_scoreboard;
    logic signed [SAMPLE_W-1:0] x_hist [NUM_TAPS];
    logic signed [SAMPLE_W-1:0] y_hist [NUM_TAPS];
    logic signed [COEF_W-1:0]   ff_c   [NUM_TAPS];
    logic signed [COEF_W-1:0]   fb_c   [NUM_TAPS];
    logic [TAPS_W-1:0]          ff_n;
    logic [TAPS_W-1:0]          fb_n;
    filt_out_t                  expected_q [$];
    int                         errors;

    function new();
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
        ff_c[i]   = '0;
        fb_c[i]   = '0;
      end
      ff_n   = FF_TAPS_RST;
      fb_n   = FB_TAPS_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TAPS_W-1:0] val);
      if (idx == REG_FF_TAPS) begin
        ff_n = val;
      end else if (idx == REG_FB_TAPS) begin
        fb_n = val;
      end
    endfunction

    // Apply one accepted item and queue the output it produces
    function void note_item(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                            logic signed [COEF_W-1:0] coef,
                            logic signed [SAMPLE_W-1:0] smp);
      longint    acc;
      longint    y;
      longint    hi;
      longint    lo;
      int        nf;
      int        nb;
      filt_out_t res;
      res.ovf = 1'b0;
      case (op)
        CMD_SAMPLE: begin
          nf = (ff_n > NUM_TAPS) ? NUM_TAPS : int'(ff_n);
          nb = (fb_n > NUM_TAPS) ? NUM_TAPS : int'(fb_n);
          hi = longint'($signed(SAMPLE_MAX));
          lo = longint'($signed(SAMPLE_MIN));
          for (int i = NUM_TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
          x_hist[0] = smp;
          acc = 0;
          for (int i = 0; i < nf; i++) acc += longint'(x_hist[i]) * longint'(ff_c[i]);
          for (int i = 0; i < nb; i++) acc -= longint'(y_hist[i]) * longint'(fb_c[i]);
          // round half up, then clamp to Q1.15
          y = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
          if (y > hi) begin
            y       = hi;
            res.ovf = 1'b1;
          end else if (y < lo) begin
            y       = lo;
            res.ovf = 1'b1;
          end
          for (int i = NUM_TAPS - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
          y_hist[0] = SAMPLE_W'(y);
        end
        CMD_WR_FF: begin
          ff_c[idx] = coef;
        end
        CMD_WR_FB: begin
          fb_c[idx] = coef;
        end
        CMD_CLEAR: begin
          foreach (x_hist[i]) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
          end
        end
      endcase
      res.sample = y_hist[0];
      expected_q.push_back(res);
    endfunction

    function void flag(string msg);
      errors++;
      $display("%s", msg);
    endfunction

    // Compare one accepted output item with the oldest expectation
    function void check_result(logic signed [SAMPLE_W-1:0] smp, logic ovf);
      filt_out_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("ERROR t=%0t unexpected item: expected none, got sample_out=%0d overflow=%0b",
                       $time, smp, ovf));
        return;
      end
      want = expected_q.pop_front();
      if (smp !== want.sample)
        flag($sformatf("ERROR t=%0t sample_out: expected %0d, got %0d", $time, want.sample, smp));
      if (ovf !== want.ovf)
        flag($sformatf("ERROR t=%0t overflow: expected %0b, got %0b", $time, want.ovf, ovf));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  logic [CMD_W-1:0]           cmd;
  logic [IDX_W-1:0]           tap_index;
  logic signed [COEF_W-1:0]   coef_value;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       overflow;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [TAPS_W-1:0]          cfg_data;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_asked   = 0;
  int hold_granted = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  filter_scoreboard sb = new();

  iir_direct_form_filter_top dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .tap_index  (tap_index),
    .coef_value (coef_value),
    .sample_in  (sample_in),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .sample_out (sample_out),
    .overflow   (overflow),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the result side: a long hold on request, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_granted != hold_asked) begin
      rsp_stall    <= 1'b1;
      hold_left    <= LONG_HOLD;
      hold_granted <= hold_granted + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check outputs before noting inputs accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) sb.check_result(sample_out, overflow);
      if (req_valid && !req_stall) sb.note_item(cmd, tap_index, coef_value, sample_in);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("iir_direct_form_filter_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct  <= 0;
        stall_pct <= 0;
      end
      IDLE_SEND: begin
        idle_pct  <= 61;
        stall_pct <= 0;
      end
      IDLE_RECV: begin
        idle_pct  <= 0;
        stall_pct <= 61;
      end
      default: begin
        idle_pct  <= 12;
        stall_pct <= 12;
      end
    endcase
  endtask

  // Offer one item, after a random gap, and hold it until accepted
  task automatic send_item(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic signed [COEF_W-1:0] coef,
                           logic signed [SAMPLE_W-1:0] smp);
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_valid  <= 1'b1;
    cmd        <= op;
    tap_index  <= idx;
    coef_value <= coef;
    sample_in  <= smp;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every expected item has come back
  task automatic wait_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write both tap counts, keeping valid high between the two writes
  task automatic write_taps(logic [TAPS_W-1:0] ff, logic [TAPS_W-1:0] fb);
    cfg_valid <= 1'b1;
    cfg_index <= REG_FF_TAPS;
    cfg_data  <= ff;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_FF_TAPS, ff);
    cfg_index <= REG_FB_TAPS;
    cfg_data  <= fb;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(REG_FB_TAPS, fb);
    cfg_valid <= 1'b0;
  endtask

  // Mostly samples; coefficients full range, at the edges, or small
  task automatic send_random();
    logic [CMD_W-1:0]           op;
    logic [IDX_W-1:0]           idx;
    logic signed [COEF_W-1:0]   coef;
    logic signed [SAMPLE_W-1:0] smp;
    int                         pick;
    pick = $urandom_range(99);
    if (pick < 70) op = CMD_SAMPLE;
    else if (pick < 83) op = CMD_WR_FF;
    else if (pick < 95) op = CMD_WR_FB;
    else op = CMD_CLEAR;
    idx = $urandom_range(NUM_TAPS - 1);
    case ($urandom_range(3))
      0: coef = COEF_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: coef = {1'b0, {(COEF_W-1){1'b1}}};
          1: coef = {1'b1, {(COEF_W-1){1'b0}}};
          2: coef = COEF_W'(1) << COEF_FRAC;
          default: coef = -(COEF_W'(1) << COEF_FRAC);
        endcase
      end
      default: coef = COEF_W'(int'($urandom_range(16383)) - 8192);
    endcase
    if ($urandom_range(7) == 0) smp = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
    else smp = SAMPLE_W'($urandom);
    send_item(op, idx, coef, smp);
  endtask

  // Saturation both ways, rounding at one half, far taps, clear, tap clamps
  task automatic run_directed();
    send_item(CMD_SAMPLE, 0, 0, 100);
    send_item(CMD_WR_FF, 0, 131071, 0);
    send_item(CMD_SAMPLE, 0, 0, 32767);
    send_item(CMD_SAMPLE, 0, 0, -32768);
    send_item(CMD_WR_FF, 0, -131072, 0);
    send_item(CMD_SAMPLE, 0, 0, -32768);
    send_item(CMD_WR_FF, 0, 2, 0);
    // products of exactly plus and minus one half LSB
    send_item(CMD_SAMPLE, 0, 0, 16384);
    send_item(CMD_SAMPLE, 0, 0, -16384);
    send_item(CMD_WR_FF, 31, 65536, 0);
    send_item(CMD_WR_FB, 0, -65536, 0);
    send_item(CMD_WR_FB, 31, 131071, 0);
    wait_results();
    write_taps(32, 32);
    send_item(CMD_SAMPLE, 0, 0, 1000);
    send_item(CMD_SAMPLE, 31, -1, 32767);
    send_item(CMD_CLEAR, 0, 0, 0);
    send_item(CMD_SAMPLE, 0, 0, -1);
    wait_results();
    // no feed-forward terms, feedback count above the maximum
    write_taps(0, 63);
    send_item(CMD_SAMPLE, 0, 0, 12345);
    wait_results();
    write_taps(63, 1);
    send_item(CMD_SAMPLE, 0, 0, -20000);
    send_item(CMD_CLEAR, 0, 0, 0);
    wait_results();
  endtask

  initial begin
    rst        <= 1'b1;
    req_valid  <= 1'b0;
    cmd        <= CMD_SAMPLE;
    tap_index  <= '0;
    coef_value <= '0;
    sample_in  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_FF_TAPS;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Random phases, each with its own tap counts and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_taps(4, 2);
        1: write_taps(32, 32);
        2: write_taps(0, 5);
        3: write_taps(63, 63);
        4: write_taps(TAPS_W'($urandom_range(8, 1)), TAPS_W'($urandom_range(8)));
        5: write_taps(16, 0);
        6: write_taps(TAPS_W'($urandom_range(63)), TAPS_W'($urandom_range(63)));
        default: write_taps(2, 1);
      endcase
      set_idling(idle_mode_t'(p % 4));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold off results while items keep coming
        if (p == 4 && n == 10) hold_asked <= hold_asked + 1;
        if (p == 5 && n == PHASE_ITEMS / 2) wait_results();
        send_random();
      end
      wait_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("iir_direct_form_filter_top: match");
    end else begin
      $display("iir_direct_form_filter_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/idf_pkg.sv
rtl/core/idf_dp.sv
rtl/core/idf_ctrl.sv
rtl/core/iir_direct_form_filter_top.sv
verif/tb_top.sv
